@@ rtl/dtdc_pkg.sv @@
// Shared types, constants and the month offset table for the date text parser.
// No dependencies; imported by every module of the block.
package dtdc_pkg;

  localparam int unsigned MAX_TEXT_CHARS = 10;

  localparam int unsigned DAY_W   = 7;
  localparam int unsigned MONTH_W = 7;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned COUNT_W = 22;
  localparam int unsigned CCNT_W  = 5;   // char counter, saturates at 31
  localparam int unsigned DCNT_W  = 3;
  localparam int unsigned CENT_W  = 8;   // years / 100

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2e;

  localparam logic [DCNT_W-1:0] DM_DIGITS_MAX   = 3'd2;
  localparam logic [DCNT_W-1:0] YEAR_DIGITS_MAX = 3'd4;

  // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for x < 2**YEAR_W
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned DIV100_W     = YEAR_W + 13;

  typedef struct packed {
    logic               valid;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } dtdc_date_t;

  // days in the months before month m of a common year
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] off;
    case (m)
      4'd1:    off = 9'd0;
      4'd2:    off = 9'd31;
      4'd3:    off = 9'd59;
      4'd4:    off = 9'd90;
      4'd5:    off = 9'd120;
      4'd6:    off = 9'd151;
      4'd7:    off = 9'd181;
      4'd8:    off = 9'd212;
      4'd9:    off = 9'd243;
      4'd10:   off = 9'd273;
      4'd11:   off = 9'd304;
      4'd12:   off = 9'd334;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

@@ rtl/dtdc_parse.sv @@
// Character parser: field state, digit accumulators, error tracking and the
// registered date record. Depends on dtdc_pkg.
module dtdc_parse
  import dtdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 accept,
  input  logic [IN_DATA_W-1:0] char_code,
  input  logic                 last_char,
  output logic                 rec_valid,
  output dtdc_date_t           rec
);

  typedef enum logic [1:0] {
    FLD_DAY   = 2'd0,
    FLD_MONTH = 2'd1,
    FLD_YEAR  = 2'd2
  } field_t;

  field_t              field, field_next;
  logic [DAY_W-1:0]    day_acc, day_acc_next;
  logic [MONTH_W-1:0]  mon_acc, mon_acc_next;
  logic [YEAR_W-1:0]   year_acc, year_acc_next;
  logic [DCNT_W-1:0]   dcnt, dcnt_next;
  logic                ferr, ferr_next;
  logic [CCNT_W-1:0]   ccnt, ccnt_next;
  logic                is_digit;
  logic [3:0]          digit;
  logic [DCNT_W-1:0]   limit;
  logic                date_ok;

  always_comb begin
    field_next    = field;
    day_acc_next  = day_acc;
    mon_acc_next  = mon_acc;
    year_acc_next = year_acc;
    dcnt_next     = dcnt;
    ferr_next     = ferr;
    ccnt_next     = (ccnt == '1) ? ccnt : ccnt + 1'b1;
    is_digit      = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    digit         = char_code[3:0];
    limit         = (field == FLD_YEAR) ? YEAR_DIGITS_MAX : DM_DIGITS_MAX;

    if (ccnt_next > CCNT_W'(MAX_TEXT_CHARS)) ferr_next = 1'b1;

    if (is_digit) begin
      if (dcnt >= limit) begin
        ferr_next = 1'b1;
      end else begin
        dcnt_next = dcnt + 1'b1;
        case (field)
          FLD_DAY:   day_acc_next = 7'((11'(day_acc) * 11'd10) + 11'(digit));
          FLD_MONTH: mon_acc_next = 7'((11'(mon_acc) * 11'd10) + 11'(digit));
          default:   year_acc_next = 14'((18'(year_acc) * 18'd10) + 18'(digit));
        endcase
      end
    end else if (char_code == CHAR_DOT) begin
      if (field == FLD_YEAR || dcnt == '0) begin
        ferr_next = 1'b1;
      end else begin
        field_next = (field == FLD_DAY) ? FLD_MONTH : FLD_YEAR;
        dcnt_next  = '0;
      end
    end else begin
      ferr_next = 1'b1;
    end

    date_ok = !ferr_next && field_next == FLD_YEAR && dcnt_next != '0 &&
              day_acc_next >= 7'd1 && day_acc_next <= 7'd31 &&
              mon_acc_next >= 7'd1 && mon_acc_next <= 7'd12;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field     <= FLD_DAY;
      day_acc   <= '0;
      mon_acc   <= '0;
      year_acc  <= '0;
      dcnt      <= '0;
      ferr      <= 1'b0;
      ccnt      <= '0;
      rec_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (last_char) begin
          field    <= FLD_DAY;
          day_acc  <= '0;
          mon_acc  <= '0;
          year_acc <= '0;
          dcnt     <= '0;
          ferr     <= 1'b0;
          ccnt     <= '0;
        end else begin
          field    <= field_next;
          day_acc  <= day_acc_next;
          mon_acc  <= mon_acc_next;
          year_acc <= year_acc_next;
          dcnt     <= dcnt_next;
          ferr     <= ferr_next;
          ccnt     <= ccnt_next;
        end
      end
      if (en) rec_valid <= accept && last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (en && accept && last_char) begin
      rec.valid <= date_ok;
      rec.day   <= day_acc_next;
      rec.month <= mon_acc_next;
      rec.year  <= year_acc_next;
    end
  end

endmodule

@@ rtl/dtdc_count.sv @@
// Day count pipeline: century split by reciprocal multiply, then leap test
// and the final sum into the output register. Depends on dtdc_pkg.
module dtdc_count
  import dtdc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   rec_valid,
  input  dtdc_date_t             rec,
  output logic                   out_valid,
  output logic [OUT_DATA_W-1:0]  out_data
);

  // stage 1
  logic [YEAR_W-1:0]   p;
  logic [DIV100_W-1:0] prod;
  logic                s1_valid;
  dtdc_date_t          s1_date;
  logic [YEAR_W-1:0]   s1_p;
  logic [CENT_W-1:0]   s1_q;

  // stage 2
  logic [YEAR_W-1:0]   rem100;
  logic                cent;
  logic                leap;
  logic [COUNT_W-1:0]  total;

  always_comb begin
    p    = (rec.year == '0) ? '0 : rec.year - 1'b1;
    prod = DIV100_W'(p) * DIV100_W'(DIV100_MUL);
  end

  always_comb begin
    rem100 = s1_p - (YEAR_W'(s1_q) * YEAR_W'(100));
    // year divisible by 100 <=> year-1 leaves 99; then year/100 = q+1
    cent   = (s1_date.year != '0) && (rem100 == YEAR_W'(99));
    leap   = (s1_date.year == '0) ||
             ((s1_date.year[1:0] == 2'b00) && (!cent || (s1_q[1:0] == 2'b11)));
    total  = (COUNT_W'(s1_p) * COUNT_W'(365))
           + COUNT_W'(s1_p >> 2)
           - COUNT_W'(s1_q)
           + COUNT_W'(s1_q >> 2)
           + COUNT_W'(month_offset(s1_date.month[3:0]))
           + COUNT_W'(leap && (s1_date.month > 7'd2))
           + COUNT_W'(s1_date.day);
    if (!s1_date.valid) total = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= rec_valid;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_date  <= rec;
      s1_p     <= p;
      s1_q     <= prod[DIV100_SHIFT +: CENT_W];
      out_data <= {5'd0, s1_date.year, s1_date.month, s1_date.day,
                   s1_date.valid, total};
    end
  end

endmodule

@@ rtl/date_text_to_day_count_top.sv @@
// Channel | dir | tdata fields (low bit up)                          | tlast
// s_      | in  | char_code[7:0]                                     | last_char
// m_      | out | day_count[21:0] date_valid day_value[6:0]          | -
//         |     | month_value[6:0] year_value[13:0], 5 zero pad bits |
// One character per cycle while the output is not stalled. The transfer of
// the final character loads the parser record register; the result then
// passes through the century register to the output register.
// rst clears parser state and the stage valid flags. While m_tvalid is held by a
// low m_tready the whole pipeline stalls and s_tready drops.
// Top level of the date text parser. Depends on dtdc_pkg, dtdc_parse, dtdc_count.
module date_text_to_day_count_top
  import dtdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // char_code
  input  logic                  s_tlast,   // last_char
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // day_count, date_valid, day, month, year
);

  logic       en;
  logic       accept;
  logic       rec_valid;
  dtdc_date_t rec;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;

  dtdc_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .accept    (accept),
    .char_code (s_tdata),
    .last_char (s_tlast),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  dtdc_count u_count (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .rec_valid (rec_valid),
    .rec       (rec),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule

@@ rtl/dtdc_checker.sv @@
// Port-level checks for the date text parser, bound to the top level.
// Depends on dtdc_pkg.
module dtdc_checker
  import dtdc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[22] |-> m_tdata[21:0] == 22'd0)
    else $error("invalid date with nonzero day count");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[22] |->
      m_tdata[29:23] >= 7'd1 && m_tdata[29:23] <= 7'd31 &&
      m_tdata[36:30] >= 7'd1 && m_tdata[36:30] <= 7'd12 &&
      m_tdata[21:0] != 22'd0)
    else $error("valid date out of range");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result after reset");

endmodule

bind date_text_to_day_count_top dtdc_checker u_dtdc_checker (.*);
